>>> design/sral_pkg.sv
`default_nettype none
package sral_pkg;

    // Field widths
    localparam int HoursW   = 5;
    localparam int MinW     = 6;
    localparam int SecW     = 6;
    localparam int ElapsedW = 17;
    localparam int LevelW   = 8;
    localparam int RampW    = 16;
    localparam int AccW     = 19;
    localparam int PcW      = 4;
    localparam int CountW   = 5;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 17;

    // Constants
    localparam logic [ElapsedW-1:0] SecsPerHour = 17'd3600;
    localparam logic [ElapsedW-1:0] SecsPerMin  = 17'd60;
    localparam logic [AccW-1:0]     SecsPerDay  = 19'd86400;
    localparam logic [AccW-1:0]     TwoDays     = 19'd172800;
    localparam logic [LevelW-1:0]   LevelMax    = 8'd255;
    localparam logic [CountW-1:0]   DivLast     = 5'(ElapsedW - 1);

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_ENABLE        = 3'd0,
        REG_ALARM_HOURS   = 3'd1,
        REG_ALARM_MINUTES = 3'd2,
        REG_ALARM_SECONDS = 3'd3,
        REG_STOP_SECONDS  = 3'd4,
        REG_RAMP_SECONDS  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic                enable;
        logic [HoursW-1:0]   alarm_hours;
        logic [MinW-1:0]     alarm_minutes;
        logic [SecW-1:0]     alarm_seconds;
        logic [ElapsedW-1:0] stop_seconds;
        logic [RampW-1:0]    ramp_seconds;
    } sral_cfg_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_DIFF      = 4'd1,
        OP_SUBDAY    = 4'd2,
        OP_SAVE_EL   = 4'd3,
        OP_DIV_INIT  = 4'd4,
        OP_DIV_STEP  = 4'd5,
        OP_SET_LEVEL = 4'd6,
        OP_STOP_CHK  = 4'd7,
        OP_START     = 4'd8,
        OP_EMIT      = 4'd9
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        CND_NEXT        = 3'd0,
        CND_ALWAYS      = 3'd1,
        CND_NOT_ENABLED = 3'd2,
        CND_NOT_RINGING = 3'd3,
        CND_LEVEL_MAX   = 3'd4,
        CND_COUNT_MORE  = 3'd5
    } cond_t;

    typedef struct packed {
        op_t            op;
        cond_t          cond;
        logic [PcW-1:0] target;
    } ucode_t;

    // Program step addresses
    localparam logic [PcW-1:0] PcDispatch = 4'd0;
    localparam logic [PcW-1:0] PcRunTest  = 4'd1;
    localparam logic [PcW-1:0] PcDiff     = 4'd2;
    localparam logic [PcW-1:0] PcSub0     = 4'd3;
    localparam logic [PcW-1:0] PcSub1     = 4'd4;
    localparam logic [PcW-1:0] PcSub2     = 4'd5;
    localparam logic [PcW-1:0] PcSaveEl   = 4'd6;
    localparam logic [PcW-1:0] PcDivInit  = 4'd7;
    localparam logic [PcW-1:0] PcDivStep  = 4'd8;
    localparam logic [PcW-1:0] PcSetLevel = 4'd9;
    localparam logic [PcW-1:0] PcStopChk  = 4'd10;
    localparam logic [PcW-1:0] PcStart    = 4'd11;
    localparam logic [PcW-1:0] PcEmit     = 4'd12;

    // Sequencer to datapath
    typedef struct packed {
        logic load;
        op_t  op;
    } sral_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic not_enabled;
        logic not_ringing;
        logic level_max;
        logic count_more;
        logic out_blocked;
    } sral_status_t;

    function automatic logic [ElapsedW-1:0] day_seconds(
        input logic [HoursW-1:0] h,
        input logic [MinW-1:0]   m,
        input logic [SecW-1:0]   s
    );
        logic [ElapsedW-1:0] t;
        t = ElapsedW'(h) * SecsPerHour + ElapsedW'(m) * SecsPerMin + ElapsedW'(s);
        return t;
    endfunction

endpackage
`default_nettype wire

>>> design/sunrise_alarm_light_ramp_unit.sv
`default_nettype none
// Sunrise alarm light ramp. Each clock sample (hours, minutes, seconds) gives one
// result: light level, ringing flag, a one-sample stop flag and the seconds elapsed
// since the alarm time. A small microcoded sequencer runs each sample through a
// fixed program; one sample is in work at a time. A disabled sample goes straight
// to emit, an idle one tests for a start, a ringing one with the level held at 255
// skips the divider, and a ramping one runs the 17-step restoring divider for
// (elapsed + 1) / ramp_seconds; emit waits while the previous result is untaken.
// Configuration writes are always ready; the user must keep them to idle periods
// only, as the block itself does not enforce this.
module sunrise_alarm_light_ramp_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sral_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [sral_pkg::CfgDataW-1:0]   cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [sral_pkg::HoursW-1:0]     now_hours,
    input  wire logic [sral_pkg::MinW-1:0]       now_minutes,
    input  wire logic [sral_pkg::SecW-1:0]       now_seconds,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [sral_pkg::LevelW-1:0]          light_level,
    output logic                                 is_ringing,
    output logic                                 stopped_now,
    output logic [sral_pkg::ElapsedW-1:0]        elapsed_seconds
);

    sral_pkg::sral_cfg_t    cfg_reg, cfg_next;
    sral_pkg::ucode_t       word;
    sral_pkg::sral_status_t status;
    sral_pkg::sral_ctrl_t   ctrl;
    logic [sral_pkg::PcW-1:0] pc;

    assign cfg_ready = 1'b1;

    // Register file write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                sral_pkg::REG_ENABLE:
                    cfg_next.enable = cfg_data[0];
                sral_pkg::REG_ALARM_HOURS:
                    cfg_next.alarm_hours = cfg_data[sral_pkg::HoursW-1:0];
                sral_pkg::REG_ALARM_MINUTES:
                    cfg_next.alarm_minutes = cfg_data[sral_pkg::MinW-1:0];
                sral_pkg::REG_ALARM_SECONDS:
                    cfg_next.alarm_seconds = cfg_data[sral_pkg::SecW-1:0];
                sral_pkg::REG_STOP_SECONDS:
                    cfg_next.stop_seconds = cfg_data[sral_pkg::ElapsedW-1:0];
                sral_pkg::REG_RAMP_SECONDS:
                    cfg_next.ramp_seconds = cfg_data[sral_pkg::RampW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.alarm_hours   <= '0;
            cfg_reg.alarm_minutes <= '0;
            cfg_reg.alarm_seconds <= '0;
            cfg_reg.stop_seconds  <= 17'd600;
            cfg_reg.ramp_seconds  <= 16'd4;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sral_ucode_rom u_rom (
        .pc   (pc),
        .word (word)
    );

    sral_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .word     (word),
        .status   (status),
        .pc       (pc),
        .ctrl     (ctrl)
    );

    sral_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .ctrl            (ctrl),
        .status          (status),
        .now_hours       (now_hours),
        .now_minutes     (now_minutes),
        .now_seconds     (now_seconds),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .light_level     (light_level),
        .is_ringing      (is_ringing),
        .stopped_now     (stopped_now),
        .elapsed_seconds (elapsed_seconds)
    );

`ifndef ASSERT_OFF
    // One sample in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a sample is in work");

    // Idle alarm shows a dark light and zero elapsed
    a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_ringing) |-> (light_level == '0 && elapsed_seconds == '0))
        else $error("level or elapsed nonzero while not ringing");

    // Stop flag only on a result that is no longer ringing
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stopped_now) |-> !is_ringing)
        else $error("stop flag with ringing still set");
`endif

endmodule
`default_nettype wire

>>> design/sral_ucode_rom.sv
`default_nettype none
module sral_ucode_rom (
    input  wire logic [sral_pkg::PcW-1:0] pc,
    output sral_pkg::ucode_t              word
);

    // Control program: one word per step
    always_comb
    begin
        unique case (pc)
            sral_pkg::PcDispatch:
                word = '{sral_pkg::OP_NOP, sral_pkg::CND_NOT_ENABLED, sral_pkg::PcEmit};
            sral_pkg::PcRunTest:
                word = '{sral_pkg::OP_NOP, sral_pkg::CND_NOT_RINGING, sral_pkg::PcStart};
            sral_pkg::PcDiff:
                word = '{sral_pkg::OP_DIFF, sral_pkg::CND_NEXT, sral_pkg::PcDispatch};
            sral_pkg::PcSub0,
            sral_pkg::PcSub1,
            sral_pkg::PcSub2:
                word = '{sral_pkg::OP_SUBDAY, sral_pkg::CND_NEXT, sral_pkg::PcDispatch};
            sral_pkg::PcSaveEl:
                word = '{sral_pkg::OP_SAVE_EL, sral_pkg::CND_LEVEL_MAX, sral_pkg::PcStopChk};
            sral_pkg::PcDivInit:
                word = '{sral_pkg::OP_DIV_INIT, sral_pkg::CND_NEXT, sral_pkg::PcDispatch};
            sral_pkg::PcDivStep:
                word = '{sral_pkg::OP_DIV_STEP, sral_pkg::CND_COUNT_MORE, sral_pkg::PcDivStep};
            sral_pkg::PcSetLevel:
                word = '{sral_pkg::OP_SET_LEVEL, sral_pkg::CND_NEXT, sral_pkg::PcDispatch};
            sral_pkg::PcStopChk:
                word = '{sral_pkg::OP_STOP_CHK, sral_pkg::CND_ALWAYS, sral_pkg::PcEmit};
            sral_pkg::PcStart:
                word = '{sral_pkg::OP_START, sral_pkg::CND_NEXT, sral_pkg::PcDispatch};
            sral_pkg::PcEmit:
                word = '{sral_pkg::OP_EMIT, sral_pkg::CND_NEXT, sral_pkg::PcDispatch};
            default:
                word = '{sral_pkg::OP_NOP, sral_pkg::CND_ALWAYS, sral_pkg::PcEmit};
        endcase
    end

endmodule
`default_nettype wire

>>> design/sral_sequencer.sv
`default_nettype none
module sral_sequencer (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire sral_pkg::ucode_t         word,
    input  wire sral_pkg::sral_status_t   status,
    output logic [sral_pkg::PcW-1:0]      pc,
    output sral_pkg::sral_ctrl_t          ctrl
);

    logic                     busy_reg, busy_next;
    logic [sral_pkg::PcW-1:0] pc_reg, pc_next;
    logic                     take_jump;
    logic                     stall;

    assign in_ready = !busy_reg;
    assign pc       = pc_reg;

    // Branch condition select
    always_comb
    begin
        unique case (word.cond)
            sral_pkg::CND_NEXT:        take_jump = 1'b0;
            sral_pkg::CND_ALWAYS:      take_jump = 1'b1;
            sral_pkg::CND_NOT_ENABLED: take_jump = status.not_enabled;
            sral_pkg::CND_NOT_RINGING: take_jump = status.not_ringing;
            sral_pkg::CND_LEVEL_MAX:   take_jump = status.level_max;
            sral_pkg::CND_COUNT_MORE:  take_jump = status.count_more;
            default:                   take_jump = 1'b0;
        endcase
    end

    // Emit waits while the output register still holds an untaken beat
    assign stall = (word.op == sral_pkg::OP_EMIT) && status.out_blocked;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        ctrl.load = 1'b0;
        ctrl.op   = sral_pkg::OP_NOP;
        if (!busy_reg)
        begin
            if (in_valid)
            begin
                busy_next = 1'b1;
                pc_next   = sral_pkg::PcDispatch;
                ctrl.load = 1'b1;
            end
        end
        else if (!stall)
        begin
            ctrl.op = word.op;
            if (word.op == sral_pkg::OP_EMIT)
            begin
                busy_next = 1'b0;
            end
            else if (take_jump)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= sral_pkg::PcDispatch;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule
`default_nettype wire

>>> design/sral_datapath.sv
`default_nettype none
module sral_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sral_pkg::sral_cfg_t           cfg,
    input  wire sral_pkg::sral_ctrl_t          ctrl,
    output sral_pkg::sral_status_t             status,
    input  wire logic [sral_pkg::HoursW-1:0]   now_hours,
    input  wire logic [sral_pkg::MinW-1:0]     now_minutes,
    input  wire logic [sral_pkg::SecW-1:0]     now_seconds,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sral_pkg::LevelW-1:0]        light_level,
    output logic                               is_ringing,
    output logic                               stopped_now,
    output logic [sral_pkg::ElapsedW-1:0]      elapsed_seconds
);

    // Latched sample
    logic [sral_pkg::HoursW-1:0]   hours_reg;
    logic [sral_pkg::MinW-1:0]     minutes_reg;
    logic [sral_pkg::SecW-1:0]     seconds_reg;

    // Alarm state
    logic                          ringing_reg, ringing_next;
    logic [sral_pkg::LevelW-1:0]   level_reg, level_next;
    logic [sral_pkg::ElapsedW-1:0] elapsed_reg, elapsed_next;
    logic                          stop_reg, stop_next;

    // Work registers
    logic [sral_pkg::AccW-1:0]     acc_reg, acc_next;
    logic [sral_pkg::ElapsedW-1:0] quot_reg, quot_next;
    logic [sral_pkg::RampW-1:0]    rem_reg, rem_next;
    logic [sral_pkg::CountW-1:0]   count_reg, count_next;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic [sral_pkg::LevelW-1:0]   out_level_reg;
    logic                          out_ringing_reg;
    logic                          out_stop_reg;
    logic [sral_pkg::ElapsedW-1:0] out_elapsed_reg;

    logic [sral_pkg::ElapsedW-1:0] now_t;
    logic [sral_pkg::ElapsedW-1:0] alarm_t;
    logic [sral_pkg::RampW-1:0]    divisor;
    logic [sral_pkg::RampW:0]      shifted;
    logic [sral_pkg::RampW:0]      trial;
    logic                          match;

    assign now_t   = sral_pkg::day_seconds(hours_reg, minutes_reg, seconds_reg);
    assign alarm_t = sral_pkg::day_seconds(cfg.alarm_hours, cfg.alarm_minutes,
                                           cfg.alarm_seconds);
    assign divisor = (cfg.ramp_seconds == '0) ? sral_pkg::RampW'(1) : cfg.ramp_seconds;
    assign match   = (hours_reg == cfg.alarm_hours) && (minutes_reg == cfg.alarm_minutes)
                     && (seconds_reg == cfg.alarm_seconds);

    // Restoring divider step: one quotient bit per cycle
    assign shifted = {rem_reg, quot_reg[sral_pkg::ElapsedW-1]};
    assign trial   = shifted - {1'b0, divisor};

    assign status.not_enabled = !cfg.enable;
    assign status.not_ringing = !ringing_reg;
    assign status.level_max   = (level_reg == sral_pkg::LevelMax);
    assign status.count_more  = (count_reg != '0);
    assign status.out_blocked = out_valid_reg && !out_ready;

    always_comb
    begin
        ringing_next = ringing_reg;
        level_next   = level_reg;
        elapsed_next = elapsed_reg;
        stop_next    = stop_reg;
        acc_next     = acc_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        count_next   = count_reg;
        if (ctrl.load)
        begin
            stop_next = 1'b0;
        end
        unique case (ctrl.op)
            sral_pkg::OP_NOP:
            begin
            end
            sral_pkg::OP_DIFF:
            begin
                acc_next = sral_pkg::AccW'(now_t) + sral_pkg::TwoDays
                           - sral_pkg::AccW'(alarm_t);
            end
            sral_pkg::OP_SUBDAY:
            begin
                if (acc_reg >= sral_pkg::SecsPerDay)
                begin
                    acc_next = acc_reg - sral_pkg::SecsPerDay;
                end
            end
            sral_pkg::OP_SAVE_EL:
            begin
                elapsed_next = acc_reg[sral_pkg::ElapsedW-1:0];
            end
            sral_pkg::OP_DIV_INIT:
            begin
                quot_next  = elapsed_reg + 1'b1;
                rem_next   = '0;
                count_next = sral_pkg::DivLast;
            end
            sral_pkg::OP_DIV_STEP:
            begin
                count_next = count_reg - 1'b1;
                if (!trial[sral_pkg::RampW])
                begin
                    rem_next  = trial[sral_pkg::RampW-1:0];
                    quot_next = {quot_reg[sral_pkg::ElapsedW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = shifted[sral_pkg::RampW-1:0];
                    quot_next = {quot_reg[sral_pkg::ElapsedW-2:0], 1'b0};
                end
            end
            sral_pkg::OP_SET_LEVEL:
            begin
                level_next = (quot_reg > sral_pkg::ElapsedW'(sral_pkg::LevelMax))
                             ? sral_pkg::LevelMax : quot_reg[sral_pkg::LevelW-1:0];
            end
            sral_pkg::OP_STOP_CHK:
            begin
                if (elapsed_reg >= cfg.stop_seconds)
                begin
                    ringing_next = 1'b0;
                    level_next   = '0;
                    elapsed_next = '0;
                    stop_next    = 1'b1;
                end
            end
            sral_pkg::OP_START:
            begin
                // level at zero elapsed is 1 / ramp
                if (match)
                begin
                    ringing_next = 1'b1;
                    elapsed_next = '0;
                    level_next   = (divisor == sral_pkg::RampW'(1))
                                   ? sral_pkg::LevelW'(1) : '0;
                end
            end
            sral_pkg::OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.op == sral_pkg::OP_EMIT)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ringing_reg   <= 1'b0;
            level_reg     <= '0;
            elapsed_reg   <= '0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            ringing_reg   <= ringing_next;
            level_reg     <= level_next;
            elapsed_reg   <= elapsed_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (ctrl.load)
        begin
            hours_reg   <= now_hours;
            minutes_reg <= now_minutes;
            seconds_reg <= now_seconds;
        end
        if (ctrl.op == sral_pkg::OP_EMIT)
        begin
            out_level_reg   <= level_reg;
            out_ringing_reg <= ringing_reg;
            out_stop_reg    <= stop_reg;
            out_elapsed_reg <= elapsed_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign light_level     = out_level_reg;
    assign is_ringing      = out_ringing_reg;
    assign stopped_now     = out_stop_reg;
    assign elapsed_seconds = out_elapsed_reg;

endmodule
`default_nettype wire

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sral_pkg::*;

    localparam int TotalSamples = 1850;
    localparam int HoldCycles   = 400;
    localparam int TailCycles   = 60;
    localparam int MaxPrinted   = 100;
    localparam int unsigned DaySecs = 86400;

    // indexes with no register behind them
    localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
    localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

    typedef struct packed {
        logic [HoursW-1:0] h;
        logic [MinW-1:0]   m;
        logic [SecW-1:0]   s;
    } clock_sample_t;

    typedef struct packed {
        logic [LevelW-1:0]   level;
        logic                ringing;
        logic                stopped;
        logic [ElapsedW-1:0] elapsed;
    } light_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [HoursW-1:0]   now_hours = '0;
    logic [MinW-1:0]     now_minutes = '0;
    logic [SecW-1:0]     now_seconds = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [LevelW-1:0]   light_level;
    logic                is_ringing;
    logic                stopped_now;
    logic [ElapsedW-1:0] elapsed_seconds;

    sunrise_alarm_light_ramp_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .now_hours       (now_hours),
        .now_minutes     (now_minutes),
        .now_seconds     (now_seconds),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .light_level     (light_level),
        .is_ringing      (is_ringing),
        .stopped_now     (stopped_now),
        .elapsed_seconds (elapsed_seconds)
    );

    // samples waiting to be driven, results waiting to be seen
    clock_sample_t sample_q[$];
    light_result_t light_q[$];

    int sent_count = 0;
    int res_count = 0;
    int err_count = 0;

    // beat flags from the last rising edge, read at the falling edge
    logic in_fire_q = 1'b0;
    logic out_fire_q = 1'b0;
    logic cfg_fire_q = 1'b0;

    int unsigned tx_gap = 0;
    int unsigned tx_calm = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_calm = 0;
    int unsigned rx_hold = 0;
    int rx_hold_req = 0;
    int rx_hold_seen = 0;

    // shadow of the alarm registers and state
    sral_cfg_t alarm_cfg = '{1'b0, 5'd0, 6'd0, 6'd0, 17'd600, 16'd4};
    logic                ring_st = 1'b0;
    logic [LevelW-1:0]   level_st = '0;
    logic [ElapsedW-1:0] elapsed_st = '0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= MaxPrinted)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // light step for a given elapsed count, ramp of zero counts as one
    function automatic int unsigned ramp_level_of(input int unsigned secs);
        int unsigned div;
        int unsigned v;
        div = (alarm_cfg.ramp_seconds == '0) ? 1 : int'(alarm_cfg.ramp_seconds);
        v = (secs + 1) / div;
        return (v > 255) ? 255 : v;
    endfunction

    // advance the alarm by one clock sample and return what it shows
    function automatic light_result_t next_light(input clock_sample_t smp);
        light_result_t r;
        int unsigned now_t;
        int unsigned al_t;
        int unsigned el;
        logic pulse;
        pulse = 1'b0;
        if (alarm_cfg.enable) begin
            if (!ring_st) begin
                // start only on an exact match of the raw fields
                if (smp.h == alarm_cfg.alarm_hours && smp.m == alarm_cfg.alarm_minutes &&
                    smp.s == alarm_cfg.alarm_seconds) begin
                    ring_st = 1'b1;
                    elapsed_st = '0;
                    level_st = LevelW'(ramp_level_of(0));
                end
            end else begin
                now_t = int'(smp.h) * 3600 + int'(smp.m) * 60 + int'(smp.s);
                al_t = int'(alarm_cfg.alarm_hours) * 3600 + int'(alarm_cfg.alarm_minutes) * 60
                     + int'(alarm_cfg.alarm_seconds);
                el = (now_t + 2 * DaySecs - al_t) % DaySecs;
                elapsed_st = ElapsedW'(el);
                // level sticks once it is full
                if (level_st < LevelMax)
                    level_st = LevelW'(ramp_level_of(el));
                if (el >= int'(alarm_cfg.stop_seconds)) begin
                    ring_st = 1'b0;
                    level_st = '0;
                    elapsed_st = '0;
                    pulse = 1'b1;
                end
            end
        end
        r.level = level_st;
        r.ringing = ring_st;
        r.stopped = pulse;
        r.elapsed = elapsed_st;
        return r;
    endfunction

    // sample driver
    always @(negedge clk) begin : drive_p
        clock_sample_t smp;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_fire_q) begin
            // beat still waiting, hold it
        end else if (tx_gap > 0) begin
            tx_gap--;
            in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
            smp = sample_q.pop_front();
            now_hours <= smp.h;
            now_minutes <= smp.m;
            now_seconds <= smp.s;
            in_valid <= 1'b1;
            // gap after this beat, with runs of back-to-back beats
            if (tx_calm > 0) begin
                tx_calm--;
                tx_gap = 0;
            end else if ($urandom_range(0, 19) == 0) begin
                tx_calm = $urandom_range(20, 60);
                tx_gap = 0;
            end else begin
                tx_gap = $urandom_range(0, 11);
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // result side ready, with per-beat stalls and long hold-offs
    always @(negedge clk) begin : accept_p
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (rx_hold_seen != rx_hold_req) begin
                rx_hold_seen = rx_hold_req;
                rx_hold = HoldCycles;
            end
            if (out_fire_q) begin
                if (rx_calm > 0) begin
                    rx_calm--;
                    rx_stall = 0;
                end else if ($urandom_range(0, 19) == 0) begin
                    rx_calm = $urandom_range(20, 60);
                    rx_stall = 0;
                end else begin
                    rx_stall = $urandom_range(0, 11);
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor: register writes, result checks, prediction per sample beat
    always @(posedge clk) begin : watch_p
        light_result_t want;
        in_fire_q <= rst_n && in_valid && in_ready;
        out_fire_q <= rst_n && out_valid && out_ready;
        cfg_fire_q <= rst_n && cfg_valid && cfg_ready;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENABLE:        alarm_cfg.enable = cfg_data[0];
                    REG_ALARM_HOURS:   alarm_cfg.alarm_hours = cfg_data[HoursW-1:0];
                    REG_ALARM_MINUTES: alarm_cfg.alarm_minutes = cfg_data[MinW-1:0];
                    REG_ALARM_SECONDS: alarm_cfg.alarm_seconds = cfg_data[SecW-1:0];
                    REG_STOP_SECONDS:  alarm_cfg.stop_seconds = cfg_data[ElapsedW-1:0];
                    REG_RAMP_SECONDS:  alarm_cfg.ramp_seconds = cfg_data[RampW-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                res_count <= res_count + 1;
                if (light_q.size() == 0) begin
                    report_mismatch("result beat with no sample waiting", light_level, 0);
                end else begin
                    want = light_q.pop_front();
                    if (light_level !== want.level)
                        report_mismatch("light_level", light_level, want.level);
                    if (is_ringing !== want.ringing)
                        report_mismatch("is_ringing", is_ringing, want.ringing);
                    if (stopped_now !== want.stopped)
                        report_mismatch("stopped_now", stopped_now, want.stopped);
                    if (elapsed_seconds !== want.elapsed)
                        report_mismatch("elapsed_seconds", elapsed_seconds, want.elapsed);
                end
            end
            if (in_valid && in_ready)
                light_q.push_back(next_light('{now_hours, now_minutes, now_seconds}));
        end
    end

    task automatic wait_drain();
        while (res_count != sent_count)
            @(posedge clk);
    endtask

    task automatic push_sample(input logic [HoursW-1:0] h, input logic [MinW-1:0] m,
                               input logic [SecW-1:0] s);
        sample_q.push_back('{h, m, s});
        sent_count++;
    endtask

    // seconds of day, wrapped into one day
    task automatic push_time(input int unsigned t);
        int unsigned w;
        w = t % DaySecs;
        push_sample(HoursW'(w / 3600), MinW'((w / 60) % 60), SecW'(w % 60));
    endtask

    // register write beat, only once every result is in
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        wait_drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(negedge clk);
        while (!cfg_fire_q);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // full register set, unused upper data bits filled with noise
    task automatic setup(input logic en, input logic [HoursW-1:0] ah,
                         input logic [MinW-1:0] am, input logic [SecW-1:0] as,
                         input logic [ElapsedW-1:0] stop, input logic [RampW-1:0] ramp);
        write_reg(REG_ENABLE, (CfgDataW'($urandom) & ~17'h1) | CfgDataW'(en));
        write_reg(REG_ALARM_HOURS, (CfgDataW'($urandom) & ~17'h1F) | CfgDataW'(ah));
        write_reg(REG_ALARM_MINUTES, (CfgDataW'($urandom) & ~17'h3F) | CfgDataW'(am));
        write_reg(REG_ALARM_SECONDS, (CfgDataW'($urandom) & ~17'h3F) | CfgDataW'(as));
        write_reg(REG_STOP_SECONDS, stop);
        write_reg(REG_RAMP_SECONDS, (CfgDataW'($urandom) & ~17'hFFFF) | CfgDataW'(ramp));
    endtask

    initial begin : stimulus_p
        int ph;
        int k;
        int runlen;
        int unsigned t;
        int unsigned al_t;
        int unsigned lead;
        logic en;
        logic [HoursW-1:0] ah;
        logic [MinW-1:0] am;
        logic [SecW-1:0] as;
        logic [ElapsedW-1:0] stop;
        logic [RampW-1:0] ramp;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled out of reset
        push_sample(5'd0, 6'd0, 6'd0);

        // midnight wrap, zero ramp, short stop
        setup(1'b1, 5'd23, 6'd59, 6'd59, 17'd3, 16'd0);
        push_sample(5'd23, 6'd59, 6'd58);
        push_sample(5'd23, 6'd59, 6'd59);
        push_sample(5'd0, 6'd0, 6'd0);
        push_sample(5'd0, 6'd0, 6'd1);
        push_sample(5'd0, 6'd0, 6'd2);
        push_sample(5'd31, 6'd63, 6'd63);

        // out of range alarm time, zero stop, widest ramp
        setup(1'b1, 5'd31, 6'd63, 6'd63, 17'd0, 16'hFFFF);
        push_sample(5'd31, 6'd63, 6'd63);
        push_sample(5'd0, 6'd0, 6'd0);
        push_sample(5'd0, 6'd0, 6'd0);

        // freeze while disabled, full level held, stop on exact equality
        setup(1'b1, 5'd0, 6'd0, 6'd0, 17'h1FFFF, 16'd1);
        push_sample(5'd0, 6'd0, 6'd0);
        push_sample(5'd0, 6'd0, 6'd1);
        write_reg(REG_ENABLE, 17'd0);
        push_sample(5'd5, 6'd5, 6'd5);
        write_reg(REG_ENABLE, 17'd1);
        push_sample(5'd0, 6'd4, 6'd15);
        push_sample(5'd0, 6'd0, 6'd2);
        push_sample(5'd1, 6'd0, 6'd0);
        write_reg(REG_STOP_SECONDS, 17'd3700);
        write_reg(RegSpareA, 17'h1FFFF);
        write_reg(RegSpareB, 17'h15555);
        push_sample(5'd1, 6'd1, 6'd40);

        // random phases: alarm runs with random content, some noise
        for (ph = 0; sent_count < TotalSamples; ph++) begin
            en = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 9) == 0) begin
                ah = HoursW'($urandom);
                am = MinW'($urandom);
                as = SecW'($urandom);
            end else begin
                ah = HoursW'($urandom_range(0, 23));
                am = MinW'($urandom_range(0, 59));
                as = SecW'($urandom_range(0, 59));
            end
            case ($urandom_range(0, 9))
                0: stop = 17'd0;
                1: stop = 17'd1;
                2: stop = 17'd86399;
                3: stop = 17'h1FFFF;
                4: stop = ElapsedW'($urandom);
                5, 6: stop = ElapsedW'($urandom_range(2, 40));
                default: stop = ElapsedW'($urandom_range(41, 400));
            endcase
            case ($urandom_range(0, 9))
                0: ramp = 16'd0;
                1, 2: ramp = 16'd1;
                3: ramp = 16'hFFFF;
                4: ramp = RampW'($urandom);
                default: ramp = RampW'($urandom_range(1, 8));
            endcase
            setup(en, ah, am, as, stop, ramp);

            al_t = int'(ah) * 3600 + int'(am) * 60 + int'(as);
            lead = $urandom_range(0, 3);
            for (k = lead; k > 0; k--)
                push_time(al_t + DaySecs - k);
            push_sample(ah, am, as);
            t = al_t;
            runlen = $urandom_range(10, 60);
            for (k = 0; k < runlen; k++) begin
                // sender pause until every result is in
                if (ph % 9 == 4 && k == runlen / 2)
                    wait_drain();
                case ($urandom_range(0, 23))
                    0: push_sample(HoursW'($urandom), MinW'($urandom), SecW'($urandom));
                    1: push_time(al_t + DaySecs - 1);
                    2, 3, 4, 5: begin
                        t = t + $urandom_range(2, 40);
                        push_time(t);
                    end
                    default: begin
                        t = t + 1;
                        push_time(t);
                    end
                endcase
            end
            // receiver holds off while the sender keeps offering
            if (ph % 12 == 2)
                rx_hold_req++;
        end

        wait_drain();
        repeat (TailCycles) @(posedge clk);
        if (light_q.size() != 0)
            report_mismatch("samples left without a result", light_q.size(), 0);
        if (err_count == 0)
            $display("sunrise_alarm_light_ramp_unit test passed");
        else
            $display("sunrise_alarm_light_ramp_unit test failed");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("sunrise_alarm_light_ramp_unit test failed");
        $finish;
    end

endmodule

>>> sim.f
design/sral_pkg.sv
design/sral_ucode_rom.sv
design/sral_sequencer.sv
design/sral_datapath.sv
design/sunrise_alarm_light_ramp_unit.sv
test/tb.sv
